/* hdl/sbd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the stale block detector.
// Depends on nothing; the slot tracker, the top level and both checkers import it.
package sbd_pkg;

  // Table geometry and allocation guard.
  localparam int SLOTS       = 16;
  localparam int GUARD_BYTES = 16;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // CRC-32 generator polynomial, MSB first.
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  // Reset value of the stale threshold register.
  localparam logic [7:0] THRESH_RESET = 8'd10;

  // Request kinds.
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_NOUSE = 3'd3;
  localparam logic [2:0] ST_STALE = 3'd4;

  // Control sequencer states.
  typedef enum logic {
    S_IDLE,
    S_RMW
  } sbd_state_e;

  // One table entry as it is kept in the entry memory.
  typedef struct packed {
    logic        is_static;
    logic [20:0] size;
    logic [31:0] crc;
    logic [7:0]  count;
  } sbd_entry_t;

  localparam int ENTRY_W = $bits(sbd_entry_t);

  // Commands from the sequencer to the slot tracker.
  typedef struct packed {
    logic              set;
    logic [SLOT_W-1:0] set_idx;
    logic              clr;
    logic [SLOT_W-1:0] clr_idx;
  } sbd_slot_cmd_t;

  // Occupancy view returned by the slot tracker.
  typedef struct packed {
    logic [SLOTS-1:0]  valid;
    logic              full;
    logic [SLOT_W-1:0] free_idx;
  } sbd_slot_stat_t;

  // Fold one byte into an MSB-first CRC without augmentation.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    logic        top;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      top = c[31];
      c   = {c[30:0], b[i]};
      if (top) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Round a request up to a multiple of four and add the guard length.
  function automatic logic [20:0] round_size(input logic [19:0] req);
    logic [20:0] r;
    r      = {1'b0, req} + 21'd3;
    r[1:0] = 2'b00;
    return r + 21'(GUARD_BYTES);
  endfunction

  // Map the 4-bit slot field onto a table index.
  function automatic logic [SLOT_W-1:0] slot_to_idx(input logic [3:0] slot);
    logic [SLOT_W+3:0] t;
    t = {{SLOT_W{1'b0}}, slot};
    return t[SLOT_W-1:0];
  endfunction

  // Map a table index onto the 4-bit slot field.
  function automatic logic [3:0] idx_to_slot(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+3:0] t;
    t = {4'b0000, idx};
    return t[3:0];
  endfunction

endpackage

/* hdl/sbd_req_if.sv */
`timescale 1ns / 1ps
// Request channel of the stale block detector: valid, ready and one request.
// Depends on nothing.
interface sbd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  slot;
  logic [19:0] request_size;
  logic        is_static;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, kind, slot, request_size, is_static, data_byte, last,
                  input ready);
  modport sink   (input valid, kind, slot, request_size, is_static, data_byte, last,
                  output ready);
endinterface

/* hdl/sbd_res_if.sv */
`timescale 1ns / 1ps
// Result channel of the stale block detector: valid, ready and one result.
// Depends on nothing.
interface sbd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot_out;
  logic [31:0] crc_value;
  logic [7:0]  unchanged_count;
  logic [25:0] used_total;

  modport source (output valid, status, slot_out, crc_value, unchanged_count, used_total,
                  input ready);
  modport sink   (input valid, status, slot_out, crc_value, unchanged_count, used_total,
                  output ready);
endinterface

/* hdl/sbd_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module sbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sbd_slot_tracker.sv */
`timescale 1ns / 1ps
// Slot occupancy: one valid flop per slot and a lowest-free-slot search.
// Depends on sbd_pkg.
module sbd_slot_tracker
  import sbd_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sbd_slot_cmd_t  cmd_i,
  output sbd_slot_stat_t stat_o
);

  logic [SLOTS-1:0]  valid_q;
  logic [SLOTS-1:0]  valid_d;
  logic [SLOT_W-1:0] free_idx;

  // Set on allocation, clear on free or stale release.
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.set) begin
      valid_d[cmd_i.set_idx] = 1'b1;
    end
    if (cmd_i.clr) begin
      valid_d[cmd_i.clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Priority search: the lowest free slot wins.
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign stat_o.valid    = valid_q;
  assign stat_o.full     = &valid_q;
  assign stat_o.free_idx = free_idx;

endmodule

/* hdl/stale_block_detector_crc32_top.sv */
`timescale 1ns / 1ps
// Top level of the stale block detector with CRC-32 change detection.
// Depends on sbd_pkg, sbd_req_if, sbd_res_if, sbd_ram and sbd_slot_tracker.
//
//   Channel   Direction  Handshake          Carries
//   req_i     in         valid / ready      kind, slot, request_size, is_static,
//                                           data_byte, last
//   res_o     out        valid / ready      status, slot_out, crc_value,
//                                           unchanged_count, used_total
//   cfg_*_i   in         write enable only  stale_threshold
//
// An allocate request or a check byte that is not last is handled in the idle
// state; an allocate result shows on the next cycle. A last check byte or a
// free reads the entry memory through its registered read port, then the entry
// is updated and written back. Reset clears all slots at once (valid flops)
// and sets the threshold to 10. A stalled result holds the sequencer in the
// write-back step; a new request is taken once the result register is free
// or is being drained.
module stale_block_detector_crc32_top
  import sbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  sbd_req_if.sink   req_i,
  sbd_res_if.source res_o,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  sbd_state_e        state_q, state_d;
  logic [7:0]        thresh_q;
  logic [31:0]       run_crc_q, run_crc_d;
  logic [25:0]       used_q, used_d;

  // Request captured for the read-modify-write step.
  logic [1:0]        kind_q;
  logic [3:0]        slot_q;
  logic [SLOT_W-1:0] idx_q;
  logic              in_range_q;
  logic [31:0]       crc_q;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [2:0]        out_status_q, out_status_d;
  logic [3:0]        out_slot_q, out_slot_d;
  logic [31:0]       out_crc_q, out_crc_d;
  logic [7:0]        out_cnt_q, out_cnt_d;
  logic [25:0]       out_used_q;

  logic              out_free;
  logic              ready;
  logic              accept;
  logic [31:0]       crc_next;
  logic [20:0]       alloc_size;
  logic [SLOT_W-1:0] req_idx;
  logic              req_in_range;

  // Entry memory ports.
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  sbd_entry_t        mem_wdata;
  logic              mem_re;
  sbd_entry_t        mem_rdata;

  sbd_slot_cmd_t     slot_cmd;
  sbd_slot_stat_t    slot_stat;

  // Read-modify-write helpers.
  logic              inuse;
  logic              crc_same;
  logic [7:0]        cnt_new;

  sbd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (req_idx),
    .rdata_o (mem_rdata)
  );

  sbd_slot_tracker u_slots (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (slot_cmd),
    .stat_o (slot_stat)
  );

  // Handshake on the request side.
  assign out_free     = !out_valid_q || res_o.ready;
  assign ready        = (state_q == S_IDLE) && out_free;
  assign accept       = req_i.valid && ready;
  assign req_i.ready  = ready;

  assign crc_next     = crc_byte(run_crc_q, req_i.data_byte);
  assign alloc_size   = round_size(req_i.request_size);
  assign req_idx      = slot_to_idx(req_i.slot);
  assign req_in_range = int'(req_i.slot) < SLOTS;

  assign inuse    = in_range_q && slot_stat.valid[idx_q];
  assign crc_same = (crc_q == mem_rdata.crc);
  assign cnt_new  = crc_same ? ((mem_rdata.count == 8'hFF) ? 8'hFF : mem_rdata.count + 8'd1)
                             : 8'd0;

  // Sequencer: request decode, entry update and result formation.
  always_comb begin
    state_d      = state_q;
    run_crc_d    = run_crc_q;
    used_d       = used_q;
    out_load     = 1'b0;
    out_status_d = ST_OK;
    out_slot_d   = 4'd0;
    out_crc_d    = 32'd0;
    out_cnt_d    = 8'd0;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    slot_cmd     = '0;
    slot_cmd.set_idx = slot_stat.free_idx;
    slot_cmd.clr_idx = idx_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            KIND_ALLOC: begin
              out_load = 1'b1;
              if (req_i.request_size == 20'd0) begin
                out_status_d = ST_ZERO;
              end else if (slot_stat.full) begin
                out_status_d = ST_FULL;
              end else begin
                slot_cmd.set        = 1'b1;
                mem_we              = 1'b1;
                mem_waddr           = slot_stat.free_idx;
                mem_wdata.is_static = req_i.is_static;
                mem_wdata.size      = alloc_size;
                mem_wdata.crc       = 32'd0;
                mem_wdata.count     = 8'd0;
                used_d              = used_q + {5'd0, alloc_size};
                out_slot_d          = idx_to_slot(slot_stat.free_idx);
              end
            end
            KIND_CHECK: begin
              if (req_i.last) begin
                run_crc_d = 32'd0;
                mem_re    = 1'b1;
                state_d   = S_RMW;
              end else begin
                run_crc_d = crc_next;
              end
            end
            KIND_FREE: begin
              mem_re  = 1'b1;
              state_d = S_RMW;
            end
            default: begin
            end
          endcase
        end
      end

      S_RMW: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_slot_d = slot_q;
          state_d    = S_IDLE;
          if (kind_q == KIND_CHECK) begin
            out_crc_d = crc_q;
            if (!inuse || mem_rdata.is_static) begin
              out_status_d = ST_NOUSE;
            end else begin
              mem_we          = 1'b1;
              mem_wdata.crc   = crc_q;
              mem_wdata.count = cnt_new;
              out_cnt_d       = cnt_new;
              if (cnt_new >= thresh_q) begin
                slot_cmd.clr = 1'b1;
                used_d       = used_q - {5'd0, mem_rdata.size};
                out_status_d = ST_STALE;
              end
            end
          end else begin
            if (!inuse) begin
              out_status_d = ST_NOUSE;
            end else begin
              slot_cmd.clr = 1'b1;
              used_d       = used_q - {5'd0, mem_rdata.size};
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thresh_q    <= THRESH_RESET;
      run_crc_q   <= 32'd0;
      used_q      <= 26'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_crc_q   <= run_crc_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
    end
  end

  // Request fields kept for the write-back step.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= req_i.kind;
      slot_q     <= req_i.slot;
      idx_q      <= req_idx;
      in_range_q <= req_in_range;
      crc_q      <= crc_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_crc_q    <= out_crc_d;
      out_cnt_q    <= out_cnt_d;
      out_used_q   <= used_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.status          = out_status_q;
  assign res_o.slot_out        = out_slot_q;
  assign res_o.crc_value       = out_crc_q;
  assign res_o.unchanged_count = out_cnt_q;
  assign res_o.used_total      = out_used_q;

endmodule

/* hdl/sbd_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the stale block detector, and the bind that
// attaches them to the top level. Depends on sbd_pkg.
module sbd_checker
  import sbd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic [19:0] in_size,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [3:0]  out_slot,
  input logic [31:0] out_crc,
  input logic [7:0]  out_count
);

  // A stalled result keeps its status and CRC.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_crc))
    else $error("stalled result changed");

  // A zero-size allocate is answered on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_kind == KIND_ALLOC && in_size == 20'd0
    |=> out_valid && out_status == ST_ZERO)
    else $error("zero-size allocate not reported");

  // A check byte that is not last yields no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_kind == KIND_CHECK && !in_last |=> !out_valid)
    else $error("result after a non-final check byte");

  // Rejected allocates carry zero slot, CRC and count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status == ST_ZERO || out_status == ST_FULL)
    |-> out_slot == 4'd0 && out_crc == 32'd0 && out_count == 8'd0)
    else $error("rejected allocate carries payload");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_status <= ST_STALE)
    else $error("undefined status code");

endmodule

bind stale_block_detector_crc32_top sbd_checker u_sbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req_i.valid),
  .in_ready   (req_i.ready),
  .in_kind    (req_i.kind),
  .in_size    (req_i.request_size),
  .in_last    (req_i.last),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .out_status (res_o.status),
  .out_slot   (res_o.slot_out),
  .out_crc    (res_o.crc_value),
  .out_count  (res_o.unchanged_count)
);

/* tb/sbd_table_checker.sv */
`timescale 1ns / 1ps
// Watches the request, result and configuration ports of the stale block detector.
// Predicts every result from its own slot table. Depends on sbd_pkg, sbd_req_if, sbd_res_if.
module sbd_table_checker
  import sbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sbd_req_if          req_mon,
  sbd_res_if          res_mon,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  // One predicted result, in the field order of the result channel.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] crc;
    logic [7:0]  count;
    logic [25:0] used;
  } table_result_t;

  // Shadow copy of the slot table, the running CRC and the threshold.
  logic        tracked      [SLOTS];
  logic        pinned       [SLOTS];
  logic [20:0] span         [SLOTS];
  logic [31:0] stored_crc   [SLOTS];
  logic [7:0]  repeat_count [SLOTS];
  logic [31:0] fold_crc;
  logic [25:0] used_sum;
  logic [7:0]  stale_limit;

  table_result_t pending_results[$];
  int unsigned   mismatch_count;

  // Shift one byte into the CRC register, MSB first, with no augmentation.
  function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] acc;
    logic        feedback;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      feedback = acc[31];
      acc = {acc[30:0], b[i]} ^ (feedback ? CRC_POLY : 32'h0);
    end
    return acc;
  endfunction

  // Update the shadow table for one accepted request and queue its result, if any.
  task automatic apply_request(input logic [1:0] kind, input logic [3:0] slot,
                               input logic [19:0] size_req, input logic pin,
                               input logic [7:0] b, input logic fin);
    table_result_t r;
    logic [31:0]   crc;
    logic [20:0]   rounded;
    logic          hit;
    int            free_slot;
    r = '0;
    hit = (int'(slot) < SLOTS) && tracked[slot];
    case (kind)
      KIND_ALLOC: begin
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!tracked[i]) free_slot = i;
        end
        if (size_req == 20'd0) begin
          r.status = ST_ZERO;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          rounded = (21'(size_req) + 21'd3) & 21'h1FFFFC;
          rounded = rounded + 21'(GUARD_BYTES);
          tracked[free_slot]      = 1'b1;
          pinned[free_slot]       = pin;
          span[free_slot]         = rounded;
          stored_crc[free_slot]   = 32'h0;
          repeat_count[free_slot] = 8'd0;
          used_sum = used_sum + 26'(rounded);
          r.status = ST_OK;
          r.slot   = 4'(free_slot);
        end
        r.used = used_sum;
        pending_results.push_back(r);
      end
      KIND_CHECK: begin
        crc = fold_byte(fold_crc, b);
        if (!fin) begin
          fold_crc = crc;
        end else begin
          // Only the slot named with the last byte matters.
          fold_crc = 32'h0;
          r.slot = slot;
          r.crc  = crc;
          if (!hit || pinned[slot]) begin
            r.status = ST_NOUSE;
          end else begin
            if (crc == stored_crc[slot]) begin
              if (repeat_count[slot] != 8'hFF) repeat_count[slot] = repeat_count[slot] + 8'd1;
            end else begin
              stored_crc[slot]   = crc;
              repeat_count[slot] = 8'd0;
            end
            r.count = repeat_count[slot];
            if (repeat_count[slot] >= stale_limit) begin
              used_sum = used_sum - 26'(span[slot]);
              tracked[slot] = 1'b0;
              r.status = ST_STALE;
            end else begin
              r.status = ST_OK;
            end
          end
          r.used = used_sum;
          pending_results.push_back(r);
        end
      end
      KIND_FREE: begin
        r.slot = slot;
        if (!hit) begin
          r.status = ST_NOUSE;
        end else begin
          used_sum = used_sum - 26'(span[slot]);
          tracked[slot] = 1'b0;
          r.status = ST_OK;
        end
        r.used = used_sum;
        pending_results.push_back(r);
      end
      default: begin
        // Unknown kinds are dropped without a result.
      end
    endcase
  endtask

  // Fold in register writes, compare accepted results, then fold in accepted requests.
  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t got;
    table_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tracked[i]      = 1'b0;
        pinned[i]       = 1'b0;
        span[i]         = '0;
        stored_crc[i]   = '0;
        repeat_count[i] = '0;
      end
      fold_crc       = '0;
      used_sum       = '0;
      stale_limit    = THRESH_RESET;
      mismatch_count = 0;
      pending_results.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) stale_limit = cfg_wdata_i;

      if (res_mon.valid && res_mon.ready) begin
        got = {res_mon.status, res_mon.slot_out, res_mon.crc_value,
               res_mon.unchanged_count, res_mon.used_total};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing pending: status %0d slot %0d crc %08h",
                     $realtime, got.status, got.slot, got.crc);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            // Fields print as status/slot/crc/count/used.
            if (mismatch_count <= 10)
              $display("%0t: mismatch: expected %0d/%0d/%08h/%0d/%0d, got %0d/%0d/%08h/%0d/%0d",
                       $realtime, want.status, want.slot, want.crc, want.count, want.used,
                       got.status, got.slot, got.crc, got.count, got.used);
          end
        end
      end

      if (req_mon.valid && req_mon.ready)
        apply_request(req_mon.kind, req_mon.slot, req_mon.request_size,
                      req_mon.is_static, req_mon.data_byte, req_mon.last);

      mismatches_o  <= mismatch_count;
      outstanding_o <= pending_results.size();
    end
  end

endmodule

/* tb/stale_block_detector_crc32_top_test.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the stale block detector: directed requests, then random
// phases at several thresholds. Depends on sbd_pkg, both channel interfaces, the block
// and sbd_table_checker.
module stale_block_detector_crc32_top_test;
  import sbd_pkg::*;

  localparam logic [1:0] KIND_NONE  = 2'd3;
  localparam int         LONG_HOLD  = 300;
  localparam int         ITEM_TOTAL = 1750;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  int unsigned mismatches;
  int unsigned outstanding;

  int unsigned items_sent;
  int unsigned hold_requests;
  int unsigned holds_done;
  logic        send_calm;
  logic        take_calm;

  // Content last used per slot, so repeated checks can find an unchanged CRC.
  logic [7:0] pattern     [16][8];
  int         pattern_len [16];

  sbd_req_if req_ch ();
  sbd_res_if res_ch ();

  stale_block_detector_crc32_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  sbd_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_ch),
    .res_mon       (res_ch),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("stale_block_detector_crc32_top_test: errors");
    $finish;
  end

  // Result side: random back-pressure per result, plus long holds when asked.
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    holds_done   = 0;
    take_calm    = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (holds_done != hold_requests) begin
        holds_done++;
        res_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if ($urandom_range(0, 31) == 0) take_calm = !take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        res_ch.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_ch.ready = 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Offer one request after a random gap and hold it until it is taken.
  task automatic send_request(input logic [1:0] kind, input logic [3:0] slot,
                              input logic [19:0] size_req, input logic pin,
                              input logic [7:0] b, input logic fin);
    int gap;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid        = 1'b1;
    req_ch.kind         = kind;
    req_ch.slot         = slot;
    req_ch.request_size = size_req;
    req_ch.is_static    = pin;
    req_ch.data_byte    = b;
    req_ch.last         = fin;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (kind != KIND_NONE) items_sent++;
  endtask

  // Stop offering, wait for every pending result, then let the block go quiet.
  task automatic settle_block();
    req_ch.valid = 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    settle_block();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // Feed one check stream with random noise in the fields the block ignores.
  task automatic check_slot(input logic [3:0] slot, input int len, input logic rescramble);
    if (rescramble) begin
      pattern_len[slot] = len;
      for (int i = 0; i < 8; i++) pattern[slot][i] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < pattern_len[slot]; i++)
      send_request(KIND_CHECK, slot, 20'($urandom_range(0, 20'hFFFFF)),
                   1'($urandom_range(0, 1)), pattern[slot][i], i == pattern_len[slot] - 1);
  endtask

  // Mostly well-formed allocate, check and free traffic, with some noise and broken streams.
  task automatic run_random(input int unsigned stop_at);
    int          roll;
    int          len;
    logic [19:0] size_req;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 14) begin
        case ($urandom_range(0, 19))
          0:       size_req = 20'd0;
          1, 2:    size_req = 20'($urandom_range(0, 20'hFFFFF));
          default: size_req = 20'($urandom_range(1, 64));
        endcase
        send_request(KIND_ALLOC, 4'($urandom_range(0, 15)), size_req,
                     $urandom_range(0, 4) == 0, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
      end else if (roll < 24) begin
        send_request(KIND_FREE, 4'($urandom_range(0, 15)), 20'($urandom_range(0, 20'hFFFFF)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
      end else if (roll < 26) begin
        send_request(KIND_NONE, 4'($urandom_range(0, 15)), 20'($urandom_range(0, 20'hFFFFF)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
      end else if (roll < 31) begin
        // Broken stream: every byte names its own slot, and the last mark may be missing.
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send_request(KIND_CHECK, 4'($urandom_range(0, 15)),
                       20'($urandom_range(0, 20'hFFFFF)),
                       1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       (i == len - 1) && ($urandom_range(0, 1) == 1));
      end else begin
        check_slot(4'($urandom_range(0, 15)), $urandom_range(1, 8), $urandom_range(0, 4) == 0);
      end
    end
  endtask

  // Main sequence: reset, directed requests, then random phases at several thresholds.
  initial begin
    req_ch.valid        = 1'b0;
    req_ch.kind         = KIND_ALLOC;
    req_ch.slot         = '0;
    req_ch.request_size = '0;
    req_ch.is_static    = 1'b0;
    req_ch.data_byte    = '0;
    req_ch.last         = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    items_sent          = 0;
    hold_requests       = 0;
    send_calm           = 1'b0;
    rst_ni              = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Allocation: zero size, smallest and largest sizes, static and dynamic.
    send_request(KIND_ALLOC, 4'h0, 20'd0,       1'b0, 8'h00, 1'b0);
    send_request(KIND_ALLOC, 4'hF, 20'd1,       1'b0, 8'hFF, 1'b1);
    send_request(KIND_ALLOC, 4'h0, 20'hFFFFF,   1'b1, 8'h00, 1'b0);
    send_request(KIND_ALLOC, 4'h0, 20'd4,       1'b0, 8'h00, 1'b0);
    // Checks of a static slot and of a free slot.
    send_request(KIND_CHECK, 4'd1, 20'hFFFFF,   1'b1, 8'hFF, 1'b1);
    send_request(KIND_CHECK, 4'd9, 20'd0,       1'b0, 8'h00, 1'b1);
    // A zero byte matches the cleared CRC, then a change, then an unchanged repeat.
    send_request(KIND_CHECK, 4'd0, 20'd0,       1'b0, 8'h00, 1'b1);
    send_request(KIND_CHECK, 4'd0, 20'd0,       1'b0, 8'hA5, 1'b0);
    send_request(KIND_CHECK, 4'd0, 20'd0,       1'b0, 8'h5A, 1'b1);
    send_request(KIND_CHECK, 4'd0, 20'd0,       1'b0, 8'hA5, 1'b0);
    send_request(KIND_CHECK, 4'd0, 20'd0,       1'b0, 8'h5A, 1'b1);
    // Earlier bytes name another slot; the last byte decides.
    send_request(KIND_CHECK, 4'd7, 20'd0,       1'b0, 8'h3C, 1'b0);
    send_request(KIND_CHECK, 4'd2, 20'd0,       1'b0, 8'hC3, 1'b1);
    // Free a static slot, free it again, free an unused slot.
    send_request(KIND_FREE,  4'd1, 20'd0,       1'b0, 8'h00, 1'b0);
    send_request(KIND_FREE,  4'd1, 20'hFFFFF,   1'b1, 8'hFF, 1'b1);
    send_request(KIND_FREE,  4'd15, 20'd0,      1'b0, 8'h00, 1'b0);
    // Unknown kind, then reuse of the freed lowest slot.
    send_request(KIND_NONE,  4'd3, 20'd12,      1'b1, 8'h81, 1'b1);
    send_request(KIND_ALLOC, 4'd0, 20'd3,       1'b0, 8'h00, 1'b0);

    for (int s = 0; s < 16; s++) begin
      pattern_len[s] = $urandom_range(1, 8);
      for (int i = 0; i < 8; i++) pattern[s][i] = 8'($urandom_range(0, 255));
    end

    write_threshold(8'd1);
    hold_requests++;
    run_random(items_sent + 350);
    write_threshold(8'd255);
    run_random(items_sent + 350);
    write_threshold(8'd0);
    run_random(items_sent + 300);
    write_threshold(8'd2);
    hold_requests++;
    run_random(items_sent + 350);
    write_threshold(8'($urandom_range(3, 20)));
    run_random(ITEM_TOTAL);

    settle_block();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0)
      $display("stale_block_detector_crc32_top_test: clean");
    else
      $display("stale_block_detector_crc32_top_test: errors");
    $finish;
  end

endmodule

/* filelist.f */
hdl/sbd_pkg.sv
hdl/sbd_req_if.sv
hdl/sbd_res_if.sv
hdl/sbd_ram.sv
hdl/sbd_slot_tracker.sv
hdl/stale_block_detector_crc32_top.sv
hdl/sbd_checker.sv
tb/sbd_table_checker.sv
tb/stale_block_detector_crc32_top_test.sv
